FILE: rtl/ssph_pkg.sv
// ----------------------------------------------------------------------------
// ssph_pkg
// Shared types, codes and constants for the sweep peak-hold analyser.
// ----------------------------------------------------------------------------
package ssph_pkg;

  localparam int BINS_DEF = 128;
  localparam int ROWS_DEF = 40;

  localparam int FREQ_W   = 30;
  localparam int STEP_W   = 24;
  localparam int LEVEL_W  = 8;
  localparam int COUNT_W  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 30;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE = 3'd4;

  // analyser modes
  localparam logic [1:0] MODE_SWEEP     = 2'd0;
  localparam logic [1:0] MODE_WATERFALL = 2'd1;
  localparam logic [1:0] MODE_SINGLE    = 2'd2;

  // item commands
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // register reset values
  localparam logic [1:0]        MODE_RESET   = MODE_SWEEP;
  localparam logic [FREQ_W-1:0] START_RESET  = 30'd300000000;
  localparam logic [FREQ_W-1:0] END_RESET    = 30'd348000000;
  localparam logic [STEP_W-1:0] STEP_RESET   = 24'd375000;
  localparam logic [FREQ_W-1:0] SINGLE_RESET = 30'd433920000;

  localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR = 8'sh80;
  localparam logic signed [LEVEL_W-1:0] LEVEL_ZERO  = 8'sh00;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_CLEAR,
    ST_FILL,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic latch_in;
    logic exec;
    logic init_step;
    logic clr_step;
    logic fill_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_wf_last;
    logic walk_bin_last;
    logic is_clear;
    logic need_fill;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/spectrum_sweep_peak_hold.sv
// ----------------------------------------------------------------------------
// spectrum_sweep_peak_hold
// Sweep analyser with per-bin peak hold, sweep peak, waterfall ring and
// single-frequency statistics.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every word of the waterfall
// memory, presetting the peak-hold memory on the way, and takes no item until
// it is done; register writes are taken throughout. An item then goes through
// accept, registered memory read, execute (read-modify-write of the peak-hold
// and waterfall memories), and hand-off to the output register, which waits
// for as long as an earlier result is still held there. A clear command adds
// a walk that resets the peak-hold memory one bin per cycle; a sample that
// ends a sweep before its last bin in waterfall mode adds a walk that fills
// the rest of the row with -128 through the single waterfall write port.
// Registers are only to be written while no item is in flight.
module spectrum_sweep_peak_hold import ssph_pkg::*; #(
  parameter int BINS = BINS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 cmd,
  input  logic signed [LEVEL_W-1:0]  rssi_dbm,
  input  logic [$clog2(ROWS)-1:0]    read_age,
  input  logic [$clog2(BINS)-1:0]    read_bin,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [$clog2(BINS)-1:0]    bin_index,
  output logic [FREQ_W-1:0]          sample_freq,
  output logic signed [LEVEL_W-1:0]  bin_peak,
  output logic signed [LEVEL_W-1:0]  sweep_peak_level,
  output logic [FREQ_W-1:0]          sweep_peak_freq,
  output logic                       sweep_done,
  output logic signed [LEVEL_W-1:0]  single_min,
  output logic signed [LEVEL_W-1:0]  single_max,
  output logic [COUNT_W-1:0]         sample_total,
  output logic signed [LEVEL_W-1:0]  read_value
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  ssph_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  ssph_dp #(
    .BINS (BINS),
    .ROWS (ROWS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .rssi_dbm         (rssi_dbm),
    .read_age         (read_age),
    .read_bin         (read_bin),
    .ctl              (ctl),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .bin_index        (bin_index),
    .sample_freq      (sample_freq),
    .bin_peak         (bin_peak),
    .sweep_peak_level (sweep_peak_level),
    .sweep_peak_freq  (sweep_peak_freq),
    .sweep_done       (sweep_done),
    .single_min       (single_min),
    .single_max       (single_max),
    .sample_total     (sample_total),
    .read_value       (read_value)
  );

`ifndef SYNTH
  // one beat in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // datapath steps never overlap
  a_steps_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.latch_in, ctl.exec, ctl.init_step, ctl.clr_step, ctl.fill_step,
              ctl.load_out}))
    else $error("overlapping datapath steps");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten");
`endif

endmodule

FILE: rtl/ssph_ctrl.sv
// ----------------------------------------------------------------------------
// ssph_ctrl
// Sequencer: start-up clear, item read/execute, walks and result hand-off.
// ----------------------------------------------------------------------------
module ssph_ctrl import ssph_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  ctl
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (stat.walk_wf_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.is_clear) state_next = ST_CLEAR;
        else if (stat.need_fill) state_next = ST_FILL;
        else state_next = ST_EMIT;
      end
      ST_CLEAR, ST_FILL: begin
        if (stat.walk_bin_last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state)
      ST_INIT: begin
        ctl.init_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready     = 1'b1;
        ctl.latch_in = in_valid;
      end
      ST_EXEC: begin
        ctl.exec = 1'b1;
      end
      ST_CLEAR: begin
        ctl.clr_step = 1'b1;
      end
      ST_FILL: begin
        ctl.fill_step = 1'b1;
      end
      ST_EMIT: begin
        ctl.load_out = stat.out_free;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

FILE: rtl/ssph_dp.sv
// ----------------------------------------------------------------------------
// ssph_dp
// Datapath: registers, peak-hold and waterfall memories, result register.
// ----------------------------------------------------------------------------
module ssph_dp import ssph_pkg::*; #(
  parameter int BINS = BINS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic [1:0]                 cmd,
  input  logic signed [LEVEL_W-1:0]  rssi_dbm,
  input  logic [$clog2(ROWS)-1:0]    read_age,
  input  logic [$clog2(BINS)-1:0]    read_bin,
  input  dp_cmd_t                    ctl,
  output dp_stat_t                   stat,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [$clog2(BINS)-1:0]    bin_index,
  output logic [FREQ_W-1:0]          sample_freq,
  output logic signed [LEVEL_W-1:0]  bin_peak,
  output logic signed [LEVEL_W-1:0]  sweep_peak_level,
  output logic [FREQ_W-1:0]          sweep_peak_freq,
  output logic                       sweep_done,
  output logic signed [LEVEL_W-1:0]  single_min,
  output logic signed [LEVEL_W-1:0]  single_max,
  output logic [COUNT_W-1:0]         sample_total,
  output logic signed [LEVEL_W-1:0]  read_value
);

  localparam int BW  = $clog2(BINS);
  localparam int RW  = $clog2(ROWS);
  localparam int WD  = ROWS * BINS;
  localparam int WAW = $clog2(WD);
  localparam int SW  = RW + 1;

  // configuration
  logic [1:0]        analyzer_mode;
  logic [FREQ_W-1:0] sweep_start, sweep_stop, watch_freq;
  logic [STEP_W-1:0] step_freq;

  // latched item
  logic [1:0]               item_cmd;
  logic signed [LEVEL_W-1:0] item_rssi;
  logic [RW-1:0]            item_age;
  logic [BW-1:0]            item_rbin;

  // block state
  logic [RW-1:0]             row_pointer;
  logic [BW-1:0]             bin_position;
  logic [FREQ_W-1:0]         current_freq;
  logic signed [LEVEL_W-1:0] peak_level, min_level, max_level;
  logic [FREQ_W-1:0]         peak_freq;
  logic [COUNT_W-1:0]        stat_count;
  logic [WAW-1:0]            walk_idx;

  // memories
  logic signed [LEVEL_W-1:0] peak_mem [BINS];
  logic signed [LEVEL_W-1:0] wf_mem [WD];
  logic signed [LEVEL_W-1:0] pk_rdata, wf_rdata;

  // result hold
  logic [BW-1:0]             res_bin;
  logic [FREQ_W-1:0]         res_freq;
  logic signed [LEVEL_W-1:0] res_bpeak, res_rd;
  logic                      res_done;

  logic                      is_sweep, is_single, wf_on, bin_last, sweep_end, rd_ok;
  logic [FREQ_W:0]           next_freq;
  logic signed [LEVEL_W-1:0] peak_base, new_peak;
  logic [RW-1:0]             row_next;
  logic [SW-1:0]             rd_sum, rd_row;
  logic [WAW-1:0]            wf_row_base, wf_raddr;
  logic                      pk_we, wf_we;
  logic [BW-1:0]             pk_waddr;
  logic [WAW-1:0]            wf_waddr;
  logic signed [LEVEL_W-1:0] pk_wdata, wf_wdata;

  assign is_single = (item_cmd == CMD_SAMPLE) && (analyzer_mode == MODE_SINGLE);
  assign is_sweep  = (item_cmd == CMD_SAMPLE) && (analyzer_mode != MODE_SINGLE);
  assign wf_on     = (analyzer_mode == MODE_WATERFALL);
  assign bin_last  = (bin_position == BW'(BINS - 1));
  assign next_freq = {1'b0, current_freq} + (FREQ_W + 1)'(step_freq);
  assign sweep_end = bin_last || (next_freq > {1'b0, sweep_stop});

  // the sweep peak restarts at the floor on the first bin of every sweep
  assign peak_base = (bin_position == '0) ? LEVEL_FLOOR : peak_level;
  always_comb begin
    if (item_rssi > pk_rdata) new_peak = item_rssi;
    else if (pk_rdata != LEVEL_FLOOR) new_peak = pk_rdata - 8'sd1;
    else new_peak = pk_rdata;
  end

  assign row_next    = (row_pointer == RW'(ROWS - 1)) ? '0 : row_pointer + 1'b1;
  assign wf_row_base = WAW'(row_pointer) * WAW'(BINS);

  // row counted from the oldest one, wrapped once round the ring
  assign rd_sum   = SW'(row_pointer) + SW'(item_age);
  assign rd_row   = (rd_sum >= SW'(ROWS)) ? rd_sum - SW'(ROWS) : rd_sum;
  assign wf_raddr = WAW'(rd_row) * WAW'(BINS) + WAW'(item_rbin);
  assign rd_ok    = (32'(item_age) < ROWS) && (32'(item_rbin) < BINS);

  assign stat.walk_wf_last  = (walk_idx == WAW'(WD - 1));
  assign stat.walk_bin_last = (walk_idx == WAW'(BINS - 1));
  assign stat.is_clear      = (item_cmd == CMD_CLEAR);
  assign stat.need_fill     = is_sweep && sweep_end && wf_on && !bin_last;
  assign stat.out_free      = !out_valid || out_ready;

  always_comb begin
    pk_we    = 1'b0;
    pk_waddr = bin_position;
    pk_wdata = new_peak;
    if (ctl.init_step && (walk_idx < WAW'(BINS))) begin
      pk_we    = 1'b1;
      pk_waddr = walk_idx[BW-1:0];
      pk_wdata = LEVEL_FLOOR;
    end else if (ctl.clr_step) begin
      pk_we    = 1'b1;
      pk_waddr = walk_idx[BW-1:0];
      pk_wdata = LEVEL_FLOOR;
    end else if (ctl.exec && is_sweep) begin
      pk_we = 1'b1;
    end
  end

  always_comb begin
    wf_we    = 1'b0;
    wf_waddr = wf_row_base + WAW'(bin_position);
    wf_wdata = item_rssi;
    if (ctl.init_step) begin
      wf_we    = 1'b1;
      wf_waddr = walk_idx;
      wf_wdata = LEVEL_ZERO;
    end else if (ctl.fill_step) begin
      wf_we    = 1'b1;
      wf_waddr = wf_row_base + WAW'(walk_idx[BW-1:0]);
      wf_wdata = LEVEL_FLOOR;
    end else if (ctl.exec && is_sweep && wf_on) begin
      wf_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pk_we) peak_mem[pk_waddr] <= pk_wdata;
    pk_rdata <= peak_mem[bin_position];
  end

  always_ff @(posedge clk) begin
    if (wf_we) wf_mem[wf_waddr] <= wf_wdata;
    wf_rdata <= wf_mem[wf_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      analyzer_mode <= MODE_RESET;
      sweep_start   <= START_RESET;
      sweep_stop    <= END_RESET;
      step_freq     <= STEP_RESET;
      watch_freq    <= SINGLE_RESET;
      row_pointer   <= '0;
      bin_position  <= '0;
      current_freq  <= START_RESET;
      peak_level    <= LEVEL_FLOOR;
      peak_freq     <= '0;
      min_level     <= LEVEL_ZERO;
      max_level     <= LEVEL_FLOOR;
      stat_count    <= '0;
      walk_idx      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:   analyzer_mode <= cfg_data[1:0];
          CFG_START:  sweep_start   <= cfg_data;
          CFG_END:    sweep_stop    <= cfg_data;
          CFG_STEP:   step_freq     <= cfg_data[STEP_W-1:0];
          CFG_SINGLE: watch_freq    <= cfg_data;
          default: ;
        endcase
      end
      if (ctl.init_step || ctl.clr_step || ctl.fill_step) walk_idx <= walk_idx + 1'b1;
      if (ctl.fill_step && stat.walk_bin_last) row_pointer <= row_next;
      if (ctl.exec) begin
        if (stat.is_clear) begin
          peak_level   <= LEVEL_FLOOR;
          peak_freq    <= '0;
          min_level    <= LEVEL_ZERO;
          max_level    <= LEVEL_FLOOR;
          stat_count   <= '0;
          bin_position <= '0;
          current_freq <= sweep_start;
          walk_idx     <= '0;
        end else if (is_single) begin
          if ((item_rssi < min_level) || (stat_count == '0)) min_level <= item_rssi;
          if ((item_rssi > max_level) || (stat_count == '0)) max_level <= item_rssi;
          if (stat_count != '1) stat_count <= stat_count + 1'b1;
        end else if (is_sweep) begin
          if (item_rssi > peak_base) begin
            peak_level <= item_rssi;
            peak_freq  <= current_freq;
          end else begin
            peak_level <= peak_base;
          end
          if (sweep_end) begin
            bin_position <= '0;
            current_freq <= sweep_start;
            if (wf_on && bin_last) row_pointer <= row_next;
            if (stat.need_fill) walk_idx <= WAW'(bin_position) + 1'b1;
          end else begin
            bin_position <= bin_position + 1'b1;
            current_freq <= next_freq[FREQ_W-1:0];
          end
        end
      end
    end
  end

  // item latch and result hold
  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      item_cmd  <= cmd;
      item_rssi <= rssi_dbm;
      item_age  <= read_age;
      item_rbin <= read_bin;
    end
    if (ctl.exec) begin
      res_bin   <= bin_position;
      res_freq  <= current_freq;
      res_bpeak <= pk_rdata;
      res_done  <= 1'b0;
      res_rd    <= LEVEL_ZERO;
      case (item_cmd)
        CMD_SAMPLE: begin
          if (is_single) begin
            res_freq <= watch_freq;
          end else begin
            res_bpeak <= new_peak;
            res_done  <= sweep_end;
          end
        end
        CMD_CLEAR: begin
          res_bin   <= '0;
          res_freq  <= sweep_start;
          res_bpeak <= LEVEL_FLOOR;
        end
        CMD_READ: begin
          if (rd_ok) res_rd <= wf_rdata;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      bin_index        <= res_bin;
      sample_freq      <= res_freq;
      bin_peak         <= res_bpeak;
      sweep_peak_level <= peak_level;
      sweep_peak_freq  <= peak_freq;
      sweep_done       <= res_done;
      single_min       <= min_level;
      single_max       <= max_level;
      sample_total     <= stat_count;
      read_value       <= res_rd;
    end
  end

endmodule
